/* design/fhps_pkg.sv */
// Shared types and constants for the fader hysteresis pickup scaler.
`timescale 1ns / 1ps

package fhps_pkg;

  localparam int POS_W = 9;

  // item kinds
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_FETCH  = 2'd1;
  localparam logic [1:0] FUNC_LOCK   = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  // register indexes (paddr[2])
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  localparam logic [15:0] INTERVAL_RST = 16'd10;
  localparam logic [7:0]  WINDOW_RST   = 8'd0;
  localparam logic [15:0] TICKS_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] sample;
    logic [6:0] target_value;
    logic       lock_value;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    send;
    logic                    locked;
  } result_t;

  typedef struct packed {
    logic [15:0] interval;
    logic [7:0]  window;
  } cfg_t;

endpackage

/* design/fhps_chan_if.sv */
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface fhps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [9:0] sample;
  logic [6:0] target_value;
  logic       lock_value;

  modport source (output valid, func, sample, target_value, lock_value, input ready);
  modport sink   (input valid, func, sample, target_value, lock_value, output ready);
endinterface

interface fhps_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] position;
  logic              send;
  logic              locked;

  modport source (output valid, position, send, locked, input ready);
  modport sink   (input valid, position, send, locked, output ready);
endinterface

/* design/fhps_cfg_regs.sv */
// APB-style configuration registers: update interval and pickup window.
`timescale 1ns / 1ps

module fhps_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output fhps_pkg::cfg_t cfg
);
  import fhps_pkg::*;

  logic [15:0] interval_r;
  logic [7:0]  window_r;
  logic        wr_en;

  // paddr[1:0] is ignored; word select only
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      window_r   <= WINDOW_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_INTERVAL) begin
        interval_r <= pwdata[15:0];
      end else begin
        window_r <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_INTERVAL) ? {16'd0, interval_r} : {24'd0, window_r};

  assign cfg.interval = interval_r;
  assign cfg.window   = window_r;

endmodule

/* design/fhps_core.sv */
// Per-item state update: tick counter, deadband, scaling and soft takeover.
`timescale 1ns / 1ps

module fhps_core #(
  parameter int DEADBAND = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  fhps_pkg::item_t  item,
  input  fhps_pkg::cfg_t   cfg,
  output fhps_pkg::result_t result
);
  import fhps_pkg::*;

  localparam int DEN = 255 - 2 * DEADBAND;
  localparam logic [9:0] DB = 10'(DEADBAND);

  typedef logic signed [POS_W-1:0] scale_tab_t [256];

  // (raw - DEADBAND) * 100 / DEN, truncated toward zero, built at elaboration
  function automatic scale_tab_t build_tab();
    scale_tab_t tab;
    int         v;
    for (int i = 0; i < 256; i++) begin
      v = ((i - DEADBAND) * 100) / DEN;
      tab[i] = v[POS_W-1:0];
    end
    return tab;
  endfunction

  localparam scale_tab_t SCALE_TAB = build_tab();

  logic [15:0]             elapsed_r, elapsed_nxt;
  logic [7:0]              last_raw_r, last_raw_nxt;
  logic                    raw_seen_r, raw_seen_nxt;
  logic signed [POS_W-1:0] position_r, position_nxt;
  logic [6:0]              target_r, target_nxt;
  logic                    lock_r, lock_nxt;
  logic                    send;

  logic [7:0]              raw;
  logic [9:0]              raw_x, ref_x;
  logic                    moved;
  logic signed [POS_W-1:0] val;
  logic signed [10:0]      val_x, win_hi, win_lo;
  logic                    in_win;
  logic                    lock_after;

  assign raw    = item.sample[9:2];
  assign raw_x  = {2'b00, raw};
  assign ref_x  = {2'b00, last_raw_r};
  assign moved  = !raw_seen_r || (raw_x + DB < ref_x) || (raw_x > ref_x + DB);
  assign val    = SCALE_TAB[raw];
  assign val_x  = {{2{val[POS_W-1]}}, val};
  assign win_hi = $signed({4'b0000, target_r}) + $signed({3'b000, cfg.window});
  assign win_lo = $signed({4'b0000, target_r}) - $signed({3'b000, cfg.window});
  assign in_win = (val_x <= win_hi) && (val_x >= win_lo);
  assign lock_after = lock_r && !in_win;

  always_comb begin
    elapsed_nxt  = elapsed_r;
    last_raw_nxt = last_raw_r;
    raw_seen_nxt = raw_seen_r;
    position_nxt = position_r;
    target_nxt   = target_r;
    lock_nxt     = lock_r;
    send         = 1'b0;
    unique case (item.func)
      FUNC_SAMPLE: begin
        if (elapsed_r > cfg.interval) begin
          elapsed_nxt = 16'd0;
          if (moved) begin
            last_raw_nxt = raw;
            raw_seen_nxt = 1'b1;
            if (val != position_r) begin
              position_nxt = val;
              lock_nxt     = lock_after;
              send         = !lock_after;
            end
          end
        end
      end
      FUNC_FETCH: begin
        target_nxt = item.target_value;
        lock_nxt   = 1'b1;
      end
      FUNC_LOCK: begin
        lock_nxt = item.lock_value;
      end
      FUNC_TICK: begin
        if (elapsed_r != TICKS_MAX) begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= 16'd0;
      last_raw_r <= 8'd0;
      raw_seen_r <= 1'b0;
      position_r <= '0;
      target_r   <= 7'd0;
      lock_r     <= 1'b0;
    end else if (step) begin
      elapsed_r  <= elapsed_nxt;
      last_raw_r <= last_raw_nxt;
      raw_seen_r <= raw_seen_nxt;
      position_r <= position_nxt;
      target_r   <= target_nxt;
      lock_r     <= lock_nxt;
    end
  end

  assign result.position = position_nxt;
  assign result.send     = send;
  assign result.locked   = lock_nxt;

endmodule

/* design/fader_hysteresis_pickup_scaler_top.sv */
// Top level of the fader hysteresis pickup scaler.
`timescale 1ns / 1ps

// Fader conditioning with soft takeover.
// in_ch carries one item per handshake: a converter sample, a fetch (pickup
// target and lock), a lock write, or a one-millisecond tick. out_ch returns
// exactly one result item per input item, in order: position, send, locked.
// An item is taken into an input register, then the state update, deadband
// test, table-based scaling and pickup window compare run combinationally
// into the result register. Throughput is 1 item per cycle while out_ch.ready
// is high, as set by the single state register loop in the core.
// When out_ch.ready is low the result register holds; the input register
// still takes one more item, after which in_ch.ready drops until the result
// is taken. Reset (rst_n low, synchronous) empties both registers, clears the
// tick count, position, target and lock, and loads the registers with
// update_interval_ms = 10 and pickup_window = 0. Configuration is written over
// the APB-style cfg_ port (interval at 0x0, window at 0x4), pready always high.
module fader_hysteresis_pickup_scaler_top #(
  parameter int DEADBAND = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  fhps_in_if.sink     in_ch,
  fhps_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fhps_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_vld_r;
  result_t core_res;
  result_t out_res_r;
  logic    out_vld_r;
  logic    advance;
  logic    in_take;

  fhps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.func         <= in_ch.func;
      in_item_r.sample       <= in_ch.sample;
      in_item_r.target_value <= in_ch.target_value;
      in_item_r.lock_value   <= in_ch.lock_value;
    end
  end

  fhps_core #(
    .DEADBAND (DEADBAND)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.position = out_res_r.position;
  assign out_ch.send     = out_res_r.send;
  assign out_ch.locked   = out_res_r.locked;

  // a transmitted position always comes from an unlocked fader
  a_send_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.send |-> !out_ch.locked)
    else $error("send with lock set");

  // only samples can produce a send
  a_send_only_sample: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.func != FUNC_SAMPLE |=> !out_res_r.send)
    else $error("send from non-sample item");

  // a held input item is not dropped while the result side stalls
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("input item lost during stall");

  // every processed item shows up as a result
  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed item without result");

endmodule
